// ----- rtl/rfb_pkg.sv -----
// ============================================================================
// rfb_pkg
// Shared types, constants and CRC-16/MODBUS helpers of the RS485 frame builder.
// ============================================================================
package rfb_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    localparam logic REG_HEADER_BYTE = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic [7:0] sequence_number;
        logic [7:0] slave_address;
        logic [7:0] command;
        logic [7:0] payload_length;
        logic [7:0] payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       end_of_run;
        logic       end_of_frame;
        logic       protocol_error;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic       close;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] crc_nib(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'h0:    v = 16'h0000;
            4'h1:    v = 16'hCC01;
            4'h2:    v = 16'hD801;
            4'h3:    v = 16'h1400;
            4'h4:    v = 16'hF001;
            4'h5:    v = 16'h3C00;
            4'h6:    v = 16'h2800;
            4'h7:    v = 16'hE401;
            4'h8:    v = 16'hA001;
            4'h9:    v = 16'h6C00;
            4'hA:    v = 16'h7800;
            4'hB:    v = 16'hB401;
            4'hC:    v = 16'h5000;
            4'hD:    v = 16'h9C01;
            4'hE:    v = 16'h8801;
            default: v = 16'h4400;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc_nib(b[3:0] ^ crc[3:0]) ^ {4'h0, crc[15:4]};
        c = crc_nib(b[7:4] ^ c[3:0]) ^ {4'h0, c[15:4]};
        return c;
    endfunction

endpackage

// ----- rtl/rfb_front.sv -----
// ============================================================================
// rfb_front
// Accepts request transfers, tracks the open frame and queues byte commands.
// ============================================================================
module rfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rfb_pkg::t_in_item i_in_data,
    input  rfb_pkg::t_q_status i_q_status,
    output logic              o_push,
    output rfb_pkg::t_cmd     o_cmd
);
    import rfb_pkg::*;

    logic       r_frame_open;
    logic [7:0] r_bytes_remaining;
    logic       n_frame_open;
    logic [7:0] n_bytes_remaining;
    logic       accept;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    always_comb begin
        n_frame_open      = r_frame_open;
        n_bytes_remaining = r_bytes_remaining;
        o_cmd.b0    = i_in_data.sequence_number;
        o_cmd.b1    = i_in_data.slave_address;
        o_cmd.b2    = i_in_data.command;
        o_cmd.b3    = i_in_data.payload_length;
        o_cmd.close = 1'b0;
        o_cmd.kind  = KIND_ERROR;
        if (i_in_data.req_type == REQ_HEADER) begin
            o_cmd.kind        = KIND_HEADER;
            o_cmd.close       = (i_in_data.payload_length == 8'd0);
            n_frame_open      = (i_in_data.payload_length != 8'd0);
            n_bytes_remaining = i_in_data.payload_length;
        end else if (r_frame_open) begin
            o_cmd.kind        = KIND_DATA;
            o_cmd.b0          = i_in_data.payload_byte;
            o_cmd.close       = (r_bytes_remaining == 8'd1);
            n_frame_open      = (r_bytes_remaining != 8'd1);
            n_bytes_remaining = r_bytes_remaining - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open      <= 1'b0;
            r_bytes_remaining <= 8'd0;
        end else if (accept) begin
            r_frame_open      <= n_frame_open;
            r_bytes_remaining <= n_bytes_remaining;
        end
    end

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open == (r_bytes_remaining != 8'd0))
        else $error("frame open flag disagrees with remaining byte count");

    a_error_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_cmd.kind == KIND_ERROR) |=> (!r_frame_open && r_bytes_remaining == 8'd0))
        else $error("error transfer changed frame state");

    a_close_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_cmd.close) |=> !r_frame_open)
        else $error("frame still open after its closing command");

endmodule

// ----- rtl/rfb_queue.sv -----
// ============================================================================
// rfb_queue
// Short command queue between the front and back parts of the frame builder.
// ============================================================================
module rfb_queue #(
    parameter int DEPTH = rfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rfb_pkg::t_cmd      i_push_cmd,
    input  logic               i_pop,
    output rfb_pkg::t_cmd      o_pop_cmd,
    output rfb_pkg::t_q_status o_status
);
    import rfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push   = i_push && !o_status.full;
    assign do_pop    = i_pop && !o_status.empty;
    assign o_pop_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into a full queue");

endmodule

// ----- rtl/rfb_back.sv -----
// ============================================================================
// rfb_back
// Emits the frame bytes of each queued command and keeps the running CRC.
// ============================================================================
module rfb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_header_byte,
    input  rfb_pkg::t_q_status i_q_status,
    input  rfb_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rfb_pkg::t_out_item o_out_data
);
    import rfb_pkg::*;

    localparam logic [2:0] STEP_FIRST  = 3'd0;
    localparam logic [2:0] STEP_SEQ    = 3'd1;
    localparam logic [2:0] STEP_ADDR   = 3'd2;
    localparam logic [2:0] STEP_CMD    = 3'd3;
    localparam logic [2:0] STEP_LEN    = 3'd4;
    localparam logic [2:0] STEP_CRC_LO = 3'd5;
    localparam logic [2:0] STEP_CRC_HI = 3'd6;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [2:0] r_step;
    logic [15:0] r_crc;
    t_out_item  r_out;
    logic       r_out_valid;

    t_out_item   cur;
    logic        feed;
    logic        last;
    logic [15:0] crc_base;
    logic [15:0] n_crc;
    logic        fire;

    always_comb begin
        cur      = '0;
        feed     = 1'b0;
        last     = 1'b0;
        crc_base = r_crc;
        case (r_cmd.kind)
            KIND_HEADER: begin
                if (r_step == STEP_FIRST) begin
                    crc_base = CRC_INIT;
                end
                feed = (r_step < STEP_CRC_LO);
                case (r_step)
                    STEP_FIRST:  cur.tx_byte = i_header_byte;
                    STEP_SEQ:    cur.tx_byte = r_cmd.b0;
                    STEP_ADDR:   cur.tx_byte = r_cmd.b1;
                    STEP_CMD:    cur.tx_byte = r_cmd.b2;
                    STEP_LEN:    cur.tx_byte = r_cmd.b3;
                    STEP_CRC_LO: cur.tx_byte = r_crc[7:0];
                    default:     cur.tx_byte = r_crc[15:8];
                endcase
                cur.end_of_frame = (r_step == STEP_CRC_HI);
                last = (r_step == STEP_LEN && !r_cmd.close) || (r_step == STEP_CRC_HI);
            end
            KIND_DATA: begin
                case (r_step)
                    STEP_FIRST: begin
                        cur.tx_byte = r_cmd.b0;
                        feed        = 1'b1;
                    end
                    STEP_SEQ: cur.tx_byte = r_crc[7:0];
                    default: begin
                        cur.tx_byte      = r_crc[15:8];
                        cur.end_of_frame = 1'b1;
                    end
                endcase
                last = (r_step == STEP_FIRST && !r_cmd.close) || (r_step == STEP_ADDR);
            end
            default: begin
                cur.protocol_error = 1'b1;
                last               = 1'b1;
            end
        endcase
        cur.end_of_run = last;
        n_crc = feed ? crc_feed(crc_base, cur.tx_byte) : r_crc;
    end

    assign fire  = r_busy && (!r_out_valid || i_out_ready);
    assign o_pop = (!r_busy || (fire && last)) && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= cur;
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_FIRST;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_crc       <= n_crc;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= STEP_FIRST;
            end else begin
                if (fire) begin
                    r_step <= r_step + 3'd1;
                end
                if (fire && last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_of_frame) |-> r_out.end_of_run)
        else $error("frame closed before the end of its run");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.protocol_error) |->
            (r_out.tx_byte == 8'd0 && r_out.end_of_run && !r_out.end_of_frame))
        else $error("malformed error result");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_CRC_HI))
        else $error("byte step out of range");

endmodule

// ----- rtl/rs485_frame_builder_crc16.sv -----
// ============================================================================
// rs485_frame_builder_crc16
// RS485 command frame builder with CRC-16/MODBUS trailer.
// ============================================================================
// Requests arrive on the input channel (i_in_valid / o_in_ready / i_in_data).
// A header request produces the header byte, sequence, slave address, command
// and length bytes; a payload request produces its data byte. The CRC follows,
// low byte first, after the last payload byte or straight after a header with
// zero length. A payload request with no frame open gives one error result.
// Result bytes leave on the output channel (o_out_valid / i_out_ready /
// o_out_data), one per cycle while the receiver takes them.
// A request's first result passes the command queue, the command register
// and the output register. A header request yields five or seven bytes and a
// payload request one to three, one per cycle while the receiver takes them.
// Requests are taken while the command queue has room, so the input side keeps
// moving during a stall of the receiver until the queue fills.
// Reset clears the queue, the open frame and the CRC and sets the header byte
// register to zero. The header byte is written over APB at addresses 0 to 3.
// ============================================================================
module rs485_frame_builder_crc16 #(
    parameter int QUEUE_DEPTH = rfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rfb_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rfb_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfb_pkg::PADDR_W-1:0] paddr,
    input  logic [rfb_pkg::PDATA_W-1:0] pwdata,
    output logic [rfb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import rfb_pkg::*;

    logic       header_wr;
    logic [7:0] r_header;
    logic       push;
    logic       pop;
    t_cmd       push_cmd;
    t_cmd       pop_cmd;
    t_q_status  q_status;
    logic       sel_header;

    assign pready     = 1'b1;
    assign sel_header = (paddr[PADDR_W-1] == REG_HEADER_BYTE);
    assign prdata     = sel_header ? {{(PDATA_W - 8){1'b0}}, r_header} : '0;
    assign header_wr  = psel && penable && pwrite && pready && sel_header;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= 8'd0;
        end else if (header_wr) begin
            r_header <= pwdata[7:0];
        end
    end

    rfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    rfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_pop_cmd  (pop_cmd),
        .o_status   (q_status)
    );

    rfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_header_byte (r_header),
        .i_q_status    (q_status),
        .i_cmd         (pop_cmd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
